### hw/rtl/twmb_pkg.sv
package twmb_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int POLY_FRAC      = 30;
  localparam int QB             = ANGLE_BITS - 2;
  localparam int U_W            = POLY_FRAC + 1;
  localparam int P_W            = 32;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int SUM_W          = TRIG_W + 1;
  localparam int SCL_W          = 16;
  localparam int PRD_W          = SUM_W + SCL_W;
  localparam int ENT_W          = 16;
  localparam int POS_W          = 32;
  localparam int N_LANE         = 6;
  localparam int N_POLY         = 7;
  localparam int N_ENT          = 9;
  localparam int NST            = 15;

  localparam logic signed [P_W-1:0] SIN_POLY [N_POLY] = '{
    32'sd61, -32'sd3864, 32'sd172272, -32'sd5026995,
    32'sd85569306, -32'sd693598669, 32'sd1686629713
  };

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [SUM_W-1:0]  rot_t;

  typedef struct packed {
    logic [3*SCL_W-1:0] scale;
    logic [3*POS_W-1:0] pos;
  } side_t;

endpackage

### hw/rtl/trs_world_matrix_builder.sv
// Throughput: one request per cycle; the whole pipeline holds while the
// last stage is full and out_tready is low.
// Reset: synchronous, active low rst_n clears every stage valid bit; data
// registers are not reset.
module trs_world_matrix_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // position_x, position_y, position_z, angle_x, angle_y, angle_z,
  // scale_x, scale_y, scale_z
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3,
  // trans_x, trans_y, trans_z
  output logic [239:0] out_tdata
);

  localparam int L   = twmb_pkg::N_LANE;
  localparam int H   = twmb_pkg::N_POLY;
  localparam int QBW = twmb_pkg::QB;

  logic adv;
  logic [twmb_pkg::NST-1:0] vld_r;
  twmb_pkg::side_t side_r [twmb_pkg::NST];

  logic [twmb_pkg::U_W-1:0] u1_r [L];
  logic [L-1:0]             n1_r;

  logic [twmb_pkg::U_W-1:0]        hz_r [H][L];
  logic [twmb_pkg::U_W-1:0]        hu_r [H][L];
  logic [L-1:0]                    hn_r [H];
  logic signed [twmb_pkg::P_W-1:0] hp_r [H][L];

  logic signed [twmb_pkg::P_W-1:0] s9_r [L];
  logic [L-1:0]                    n9_r;
  twmb_pkg::trig_t                 t10_r [L];

  twmb_pkg::trig_t czcy_r, szcy_r, czsy_r, szsy_r, cysx_r;
  twmb_pkg::trig_t czcx_r, szcx_r, szsx_r, czsx_r, cycx_r;
  twmb_pkg::trig_t sx11_r, cx11_r, sy11_r;

  twmb_pkg::trig_t czcy12_r, szcy12_r, cysx12_r, czcx12_r, szcx12_r;
  twmb_pkg::trig_t szsx12_r, czsx12_r, cycx12_r, sy12_r;
  twmb_pkg::trig_t czsysx_r, szsysx_r, czsycx_r, szsycx_r;

  twmb_pkg::rot_t rot_r [twmb_pkg::N_ENT];
  logic signed [twmb_pkg::PRD_W-1:0] prd_r [twmb_pkg::N_ENT];
  logic signed [twmb_pkg::ENT_W-1:0] ent_r [twmb_pkg::N_ENT];

  logic [twmb_pkg::U_W-1:0]        u1_nxt [L];
  logic [L-1:0]                    n1_nxt;
  logic [twmb_pkg::U_W-1:0]        z_nxt [L];
  logic signed [twmb_pkg::P_W-1:0] hp_nxt [H][L];
  logic signed [twmb_pkg::P_W-1:0] s9_nxt [L];
  twmb_pkg::trig_t                 t10_nxt [L];
  twmb_pkg::side_t                 side_nxt;

  function automatic twmb_pkg::trig_t tmul(twmb_pkg::trig_t a, twmb_pkg::trig_t b);
    logic signed [2*twmb_pkg::TRIG_W-1:0] p;
    p = a * b + (2*twmb_pkg::TRIG_W)'(1 << (twmb_pkg::TRIG_FRAC_BITS - 1));
    return twmb_pkg::TRIG_W'(p >>> twmb_pkg::TRIG_FRAC_BITS);
  endfunction

  assign adv        = !vld_r[twmb_pkg::NST-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[twmb_pkg::NST-1];

  assign side_nxt.pos   = in_tdata[95:0];
  assign side_nxt.scale = in_tdata[191:144];

  always_comb begin
    logic [twmb_pkg::ANGLE_BITS-1:0] a;
    logic [QBW-1:0]                  r;
    logic [twmb_pkg::QB:0]           rr;
    for (int l = 0; l < L; l++) begin
      a = in_tdata[96 + 16*(l/2) +: 16];
      if (l % 2 == 1) begin
        a = a + twmb_pkg::ANGLE_BITS'(1 << twmb_pkg::QB);
      end
      r = a[twmb_pkg::QB-1:0];
      if (a[twmb_pkg::QB]) begin
        rr = (twmb_pkg::QB+1)'(1 << twmb_pkg::QB) - {1'b0, r};
      end else begin
        rr = {1'b0, r};
      end
      u1_nxt[l] = twmb_pkg::U_W'({rr, {(twmb_pkg::POLY_FRAC - twmb_pkg::QB){1'b0}}});
      n1_nxt[l] = a[twmb_pkg::ANGLE_BITS-1];
    end
  end

  always_comb begin
    logic [2*twmb_pkg::U_W-1:0]        sq;
    logic signed [2*twmb_pkg::P_W-1:0] pm;
    logic signed [twmb_pkg::P_W-1:0]   s;
    logic signed [twmb_pkg::P_W-1:0]   rs;
    for (int l = 0; l < L; l++) begin
      sq = u1_r[l] * u1_r[l];
      z_nxt[l] = sq[twmb_pkg::POLY_FRAC +: twmb_pkg::U_W];
      hp_nxt[0][l] = twmb_pkg::SIN_POLY[0];
      for (int k = 1; k < H; k++) begin
        pm = hp_r[k-1][l] * $signed({1'b0, hz_r[k-1][l]});
        hp_nxt[k][l] = twmb_pkg::SIN_POLY[k] + twmb_pkg::P_W'(pm >>> twmb_pkg::POLY_FRAC);
      end
      pm = hp_r[H-1][l] * $signed({1'b0, hu_r[H-1][l]});
      s9_nxt[l] = twmb_pkg::P_W'(pm >>> twmb_pkg::POLY_FRAC);
      s = s9_r[l] + twmb_pkg::P_W'(1 << (twmb_pkg::POLY_FRAC - twmb_pkg::TRIG_FRAC_BITS - 1));
      rs = s >>> (twmb_pkg::POLY_FRAC - twmb_pkg::TRIG_FRAC_BITS);
      if (rs < 0) begin
        rs = '0;
      end else if (rs > twmb_pkg::P_W'(1 << twmb_pkg::TRIG_FRAC_BITS)) begin
        rs = twmb_pkg::P_W'(1 << twmb_pkg::TRIG_FRAC_BITS);
      end
      if (n9_r[l]) begin
        rs = -rs;
      end
      t10_nxt[l] = twmb_pkg::TRIG_W'(rs);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[twmb_pkg::NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [twmb_pkg::SCL_W-1:0] sc;
    logic signed [twmb_pkg::PRD_W:0]   v;
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int k = 1; k < twmb_pkg::NST; k++) begin
        side_r[k] <= side_r[k-1];
      end
      u1_r <= u1_nxt;
      n1_r <= n1_nxt;
      for (int l = 0; l < L; l++) begin
        hz_r[0][l] <= z_nxt[l];
        hu_r[0][l] <= u1_r[l];
        hp_r[0][l] <= hp_nxt[0][l];
        for (int k = 1; k < H; k++) begin
          hz_r[k][l] <= hz_r[k-1][l];
          hu_r[k][l] <= hu_r[k-1][l];
          hp_r[k][l] <= hp_nxt[k][l];
        end
        s9_r[l]  <= s9_nxt[l];
        t10_r[l] <= t10_nxt[l];
      end
      hn_r[0] <= n1_r;
      for (int k = 1; k < H; k++) begin
        hn_r[k] <= hn_r[k-1];
      end
      n9_r <= hn_r[H-1];

      czcy_r <= tmul(t10_r[5], t10_r[3]);
      szcy_r <= tmul(t10_r[4], t10_r[3]);
      czsy_r <= tmul(t10_r[5], t10_r[2]);
      szsy_r <= tmul(t10_r[4], t10_r[2]);
      cysx_r <= tmul(t10_r[3], t10_r[0]);
      czcx_r <= tmul(t10_r[5], t10_r[1]);
      szcx_r <= tmul(t10_r[4], t10_r[1]);
      szsx_r <= tmul(t10_r[4], t10_r[0]);
      czsx_r <= tmul(t10_r[5], t10_r[0]);
      cycx_r <= tmul(t10_r[3], t10_r[1]);
      sx11_r <= t10_r[0];
      cx11_r <= t10_r[1];
      sy11_r <= t10_r[2];

      czsysx_r <= tmul(czsy_r, sx11_r);
      szsysx_r <= tmul(szsy_r, sx11_r);
      czsycx_r <= tmul(czsy_r, cx11_r);
      szsycx_r <= tmul(szsy_r, cx11_r);
      czcy12_r <= czcy_r;
      szcy12_r <= szcy_r;
      cysx12_r <= cysx_r;
      czcx12_r <= czcx_r;
      szcx12_r <= szcx_r;
      szsx12_r <= szsx_r;
      czsx12_r <= czsx_r;
      cycx12_r <= cycx_r;
      sy12_r   <= sy11_r;

      rot_r[0] <= twmb_pkg::SUM_W'(czcy12_r);
      rot_r[1] <= twmb_pkg::SUM_W'(szcy12_r);
      rot_r[2] <= -twmb_pkg::SUM_W'(sy12_r);
      rot_r[3] <= twmb_pkg::SUM_W'(czsysx_r) - twmb_pkg::SUM_W'(szcx12_r);
      rot_r[4] <= twmb_pkg::SUM_W'(szsysx_r) + twmb_pkg::SUM_W'(czcx12_r);
      rot_r[5] <= twmb_pkg::SUM_W'(cysx12_r);
      rot_r[6] <= twmb_pkg::SUM_W'(czsycx_r) + twmb_pkg::SUM_W'(szsx12_r);
      rot_r[7] <= twmb_pkg::SUM_W'(szsycx_r) - twmb_pkg::SUM_W'(czsx12_r);
      rot_r[8] <= twmb_pkg::SUM_W'(cycx12_r);

      for (int e = 0; e < twmb_pkg::N_ENT; e++) begin
        sc = side_r[12].scale[twmb_pkg::SCL_W*(e/3) +: twmb_pkg::SCL_W];
        prd_r[e] <= rot_r[e] * sc;
        v = (twmb_pkg::PRD_W+1)'(prd_r[e])
          + (twmb_pkg::PRD_W+1)'(1 << (twmb_pkg::TRIG_FRAC_BITS - 1));
        v = v >>> twmb_pkg::TRIG_FRAC_BITS;
        if (v > 32767) begin
          ent_r[e] <= 16'sh7fff;
        end else if (v < -32768) begin
          ent_r[e] <= 16'sh8000;
        end else begin
          ent_r[e] <= twmb_pkg::ENT_W'(v);
        end
      end
    end
  end

  always_comb begin
    for (int e = 0; e < twmb_pkg::N_ENT; e++) begin
      out_tdata[twmb_pkg::ENT_W*e +: twmb_pkg::ENT_W] = ent_r[e];
    end
    out_tdata[239:144] = side_r[twmb_pkg::NST-1].pos;
  end

endmodule

### test/trs_world_matrix_builder_tb.sv
`timescale 1ns / 1ps

module trs_world_matrix_builder_tb;

  localparam int RANDOM_ITEMS = 1630;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PF           = twmb_pkg::POLY_FRAC;
  localparam int TF           = twmb_pkg::TRIG_FRAC_BITS;
  localparam int QBT          = twmb_pkg::QB;

  typedef struct {
    logic [191:0] req;
    bit           typed;
    logic [239:0] matrix;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [239:0] out_tdata;

  logic [239:0] matrix_q[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           result_count = 0;
  string        field_name[12] = '{"r1c1", "r1c2", "r1c3", "r2c1", "r2c2", "r2c3",
                                   "r3c1", "r3c2", "r3c3", "trans_x", "trans_y", "trans_z"};

  trs_world_matrix_builder dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [191:0] pack_req(logic [31:0] px, logic [31:0] py,
                                            logic [31:0] pz, logic [15:0] ax,
                                            logic [15:0] ay, logic [15:0] az,
                                            logic [15:0] kx, logic [15:0] ky,
                                            logic [15:0] kz);
    return {kz, ky, kx, az, ay, ax, pz, py, px};
  endfunction

  function automatic logic [239:0] diag_matrix(logic [15:0] dx, logic [15:0] dy,
                                               logic [15:0] dz, logic [191:0] req);
    return {req[95:0], dz, 32'd0, 16'd0, dy, 32'd0, 16'd0, dx};
  endfunction

  function automatic longint quarter_wave(longint u);
    longint z, p, s;
    z = (u * u) >>> PF;
    p = twmb_pkg::SIN_POLY[0];
    for (int i = 1; i < twmb_pkg::N_POLY; i++) begin
      p = longint'(twmb_pkg::SIN_POLY[i]) + ((p * z) >>> PF);
    end
    s = (p * u) >>> PF;
    s = (s + (longint'(1) << (PF - TF - 1))) >>> (PF - TF);
    if (s < 0) s = 0;
    if (s > (longint'(1) << TF)) s = longint'(1) << TF;
    return s;
  endfunction

  function automatic longint angle_sine(longint a);
    longint quad, rem, v;
    a    = a & ((longint'(1) << twmb_pkg::ANGLE_BITS) - 1);
    quad = (a >> QBT) & 3;
    rem  = a & ((longint'(1) << QBT) - 1);
    if (quad[0]) rem = (longint'(1) << QBT) - rem;
    v = quarter_wave(rem << (PF - QBT));
    return quad[1] ? -v : v;
  endfunction

  function automatic longint angle_cosine(longint a);
    return angle_sine(a + (longint'(1) << QBT));
  endfunction

  function automatic longint trig_product(longint a, longint b);
    return (a * b + (longint'(1) << (TF - 1))) >>> TF;
  endfunction

  function automatic logic [15:0] scale_entry(longint rot, logic [15:0] k);
    longint v;
    v = (rot * longint'($signed(k)) + (longint'(1) << (TF - 1))) >>> TF;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [239:0] world_matrix(logic [191:0] req);
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    logic [15:0] kx, ky, kz;
    logic [239:0] m;
    sx = angle_sine(req[111:96]);
    cx = angle_cosine(req[111:96]);
    sy = angle_sine(req[127:112]);
    cy = angle_cosine(req[127:112]);
    sz = angle_sine(req[143:128]);
    cz = angle_cosine(req[143:128]);
    kx = req[159:144];
    ky = req[175:160];
    kz = req[191:176];
    czsy = trig_product(cz, sy);
    szsy = trig_product(sz, sy);
    m[15:0]    = scale_entry(trig_product(cz, cy), kx);
    m[31:16]   = scale_entry(trig_product(sz, cy), kx);
    m[47:32]   = scale_entry(-sy, kx);
    m[63:48]   = scale_entry(trig_product(czsy, sx) - trig_product(sz, cx), ky);
    m[79:64]   = scale_entry(trig_product(szsy, sx) + trig_product(cz, cx), ky);
    m[95:80]   = scale_entry(trig_product(cy, sx), ky);
    m[111:96]  = scale_entry(trig_product(czsy, cx) + trig_product(sz, sx), kz);
    m[127:112] = scale_entry(trig_product(szsy, cx) - trig_product(cz, sx), kz);
    m[143:128] = scale_entry(trig_product(cy, cx), kz);
    m[239:144] = req[95:0];
    return m;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
      1: return 16'($urandom_range(0, 3) << 14);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'(int'($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  task automatic send_request(logic [191:0] req, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic [239:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      result_count <= result_count + 1;
      if (matrix_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        error_count++;
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (out_tdata[16*i +: 16] !== want[16*i +: 16]) begin
            $error("%s expected %h got %h", field_name[i], want[16*i +: 16],
                   out_tdata[16*i +: 16]);
            error_count++;
          end
        end
        for (int i = 0; i < 3; i++) begin
          if (out_tdata[144+32*i +: 32] !== want[144+32*i +: 32]) begin
            $error("%s expected %h got %h", field_name[9+i], want[144+32*i +: 32],
                   out_tdata[144+32*i +: 32]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (result_count == 120) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        gap = 0;
      end else begin
        gap = ((result_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    row_t         rows[$];
    logic [191:0] req;
    int           gap;

    req = pack_req(0, 0, 0, 0, 0, 0, 16'h0100, 16'h0100, 16'h0100);
    rows.push_back('{req, 1'b1, diag_matrix(16'h0100, 16'h0100, 16'h0100, req)});
    req = pack_req(32'h7fffffff, 32'h80000000, 32'hffffffff, 0, 0, 0,
                   16'h0100, 16'h0100, 16'h0100);
    rows.push_back('{req, 1'b1, diag_matrix(16'h0100, 16'h0100, 16'h0100, req)});
    req = pack_req(32'h80000000, 32'h7fffffff, 32'h00000001, 0, 0, 0,
                   16'h7fff, 16'h7fff, 16'h7fff);
    rows.push_back('{req, 1'b1, diag_matrix(16'h7fff, 16'h7fff, 16'h7fff, req)});
    req = pack_req(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 0, 0, 0,
                   16'h8000, 16'h8000, 16'h8000);
    rows.push_back('{req, 1'b1, diag_matrix(16'h8000, 16'h8000, 16'h8000, req)});
    req = pack_req(32'haaaaaaaa, 32'h55555555, 32'hdeadbeef, 16'h1234, 16'hfedc,
                   16'h8765, 0, 0, 0);
    rows.push_back('{req, 1'b1, diag_matrix(0, 0, 0, req)});
    req = pack_req(1, 2, 3, 0, 0, 0, 16'hff00, 16'h0200, 16'hff80);
    rows.push_back('{req, 1'b1, diag_matrix(16'hff00, 16'h0200, 16'hff80, req)});
    rows.push_back('{pack_req(0, 0, 0, 16'h4000, 0, 0, 16'h0100, 16'h0100, 16'h0100), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 0, 16'h4000, 0, 16'h0100, 16'h0100, 16'h0100), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 0, 0, 16'h4000, 16'h0100, 16'h0100, 16'h0100), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h0100, 16'h0100,
                              16'h0100), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 16'hc000, 16'hc000, 16'hc000, 16'h0100, 16'h0100,
                              16'h0100), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff,
                              16'h7fff), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 16'h0001, 16'h3fff, 16'h4001, 16'h8000, 16'h8000,
                              16'h8000), 0, '0});
    rows.push_back('{pack_req(5, 6, 7, 16'h2000, 16'h2000, 16'h2000, 16'h7fff, 16'h8000,
                              16'h7fff), 0, '0});
    rows.push_back('{pack_req(9, 8, 7, 16'h6000, 16'ha000, 16'he000, 16'hfe00, 16'h0180,
                              16'hff01), 0, '0});
    rows.push_back('{pack_req(0, 0, 0, 16'h7fff, 16'h8001, 16'hbfff, 16'h0001, 16'hffff,
                              16'h0001), 0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      matrix_q.push_back(rows[i].typed ? rows[i].matrix : world_matrix(rows[i].req));
      send_request(rows[i].req, $urandom_range(0, 4));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      req = pack_req($urandom, $urandom, $urandom, pick_angle(), pick_angle(), pick_angle(),
                     pick_scale(), pick_scale(), pick_scale());
      gap = ((n / 200) % 3 == 1) ? 0 : $urandom_range(0, 4);
      matrix_q.push_back(world_matrix(req));
      send_request(req, gap);
    end
    in_tvalid <= 1'b0;

    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/twmb_pkg.sv
hw/rtl/trs_world_matrix_builder.sv
test/trs_world_matrix_builder_tb.sv
